/* hw/rtl/hbfe_pkg.sv */
// Shared types, constants and derivation functions for the heartbeat fade envelope.
// No dependencies; imported by every module of the block.
`default_nettype none

package hbfe_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned LEVEL_W  = 7;
	localparam int unsigned PERIOD_W = 11;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 3;

	localparam logic [TIME_W-1:0]   UPDATE_MS     = 32'd50;
	localparam logic [PERIOD_W-1:0] SLOW_MS       = 11'd1200;
	// speed 0 truncates -800/99 toward zero, giving 1200 + 8
	localparam logic [PERIOD_W-1:0] SPEED0_MS     = 11'd1208;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX     = 7'd100;
	localparam logic [LEVEL_W-1:0]  RISE_STEP     = 7'd5;
	localparam logic [LEVEL_W-1:0]  FALL_STEP     = 7'd3;
	localparam logic [LEVEL_W-1:0]  PEAK1_BASE    = 7'd50;
	localparam logic [LEVEL_W-1:0]  PEAK2_BASE    = 7'd30;
	localparam logic [CFG_W-1:0]    SPEED_RST     = 7'd50;
	localparam logic [CFG_W-1:0]    INTENSITY_RST = 7'd50;

	// ceil(800 * 2^16 / 99) and ceil(50 * 2^16 / 99); exact floor for 7-bit operands
	localparam logic [19:0] PERIOD_RECIP = 20'd529584;
	localparam logic [15:0] PEAK_RECIP   = 16'd33099;

	localparam logic REG_SPEED     = 1'b0;
	localparam logic REG_INTENSITY = 1'b1;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [LEVEL_W-1:0]  peak1;
		logic [LEVEL_W-1:0]  peak2;
	} hbfe_param_t;

	function automatic logic [PERIOD_W-1:0] beat_period(input logic [CFG_W-1:0] speed);
		logic [CFG_W-1:0] s;
		logic [26:0]      prod;
		logic [PERIOD_W-1:0] q;
		s    = speed - 7'd1;
		prod = 27'(s) * 27'(PERIOD_RECIP);
		q    = prod[26:16];
		if (speed == '0) begin
			return SPEED0_MS;
		end
		return SLOW_MS - q;
	endfunction

	function automatic logic [LEVEL_W-1:0] peak_level(input logic [LEVEL_W-1:0] base,
		input logic [CFG_W-1:0] intensity);
		logic [CFG_W-1:0] i;
		logic [22:0]      prod;
		logic [7:0]       sum;
		// intensity 0 truncates to a zero offset, same as intensity 1
		i    = (intensity == '0) ? '0 : intensity - 7'd1;
		prod = 23'(i) * 23'(PEAK_RECIP);
		sum  = 8'(base) + 8'(prod[21:16]);
		if (sum > 8'(LEVEL_MAX)) begin
			return LEVEL_MAX;
		end
		return sum[LEVEL_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/hbfe_cfg.sv */
// APB register file for speed and intensity, plus the registered beat parameters
// derived from them. Depends on hbfe_pkg.
`default_nettype none

module hbfe_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hbfe_pkg::ADDR_W-1:0] paddr,
	input  wire logic [hbfe_pkg::DATA_W-1:0] pwdata,
	output logic      [hbfe_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output hbfe_pkg::hbfe_param_t            param
);
	import hbfe_pkg::*;

	logic [CFG_W-1:0] speed_q;
	logic [CFG_W-1:0] intensity_q;
	logic             wr_en;
	logic             idx;

	assign pready = 1'b1;
	assign idx    = paddr[2];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= SPEED_RST;
			intensity_q <= INTENSITY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SPEED:     speed_q     <= pwdata[CFG_W-1:0];
				REG_INTENSITY: intensity_q <= pwdata[CFG_W-1:0];
				default:       speed_q     <= speed_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SPEED:     prdata = DATA_W'(speed_q);
			REG_INTENSITY: prdata = DATA_W'(intensity_q);
			default:       prdata = '0;
		endcase
	end

	// register period and peaks derived from the stored speed and intensity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			param.period <= beat_period(SPEED_RST);
			param.peak1  <= peak_level(PEAK1_BASE, INTENSITY_RST);
			param.peak2  <= peak_level(PEAK2_BASE, INTENSITY_RST);
		end else begin
			param.period <= beat_period(speed_q);
			param.peak1  <= peak_level(PEAK1_BASE, intensity_q);
			param.peak2  <= peak_level(PEAK2_BASE, intensity_q);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hbfe_core.sv */
// Input register, beat state and fade update logic, and the result register.
// Depends on hbfe_pkg.
`default_nettype none

module hbfe_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire hbfe_pkg::hbfe_param_t        param,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [hbfe_pkg::TIME_W-1:0]  now_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [hbfe_pkg::LEVEL_W-1:0] fade_level
);
	import hbfe_pkg::*;

	logic                valid_s1;
	logic [TIME_W-1:0]   now_s1;
	logic [TIME_W-1:0]   last_upd_q;
	logic [TIME_W-1:0]   last_beat_q;
	logic [LEVEL_W-1:0]  level_q;

	logic                upd;
	logic                restart;
	logic                s1_go;
	logic                upd_go;
	logic [TIME_W-1:0]   since_upd;
	logic [TIME_W-1:0]   since_beat;
	logic [PERIOD_W-1:0] elapsed;
	logic [LEVEL_W-1:0]  target;
	logic [LEVEL_W-1:0]  level_nxt;
	logic [15:0]         el20;
	logic [15:0]         per3;

	always_comb begin
		since_upd  = now_s1 - last_upd_q;
		upd        = since_upd >= UPDATE_MS;
		since_beat = now_s1 - last_beat_q;
		restart    = since_beat >= TIME_W'(param.period);
		// after the restart check elapsed is below the period
		elapsed    = restart ? '0 : since_beat[PERIOD_W-1:0];

		// phase compares reduced: 100e<15p, 100e<25p, 100e<40p
		el20 = 16'(elapsed) * 16'd20;
		per3 = 16'(param.period) * 16'd3;
		if (el20 < per3) begin
			target = param.peak1;
		end else if ((15'(elapsed) << 2) < 15'(param.period)) begin
			target = '0;
		end else if (15'(elapsed) * 15'd5 < (15'(param.period) << 1)) begin
			target = param.peak2;
		end else begin
			target = '0;
		end

		if (level_q < target) begin
			level_nxt = (level_q + RISE_STEP >= target) ? target : level_q + RISE_STEP;
		end else if (level_q > target) begin
			level_nxt = (level_q > target + FALL_STEP) ? level_q - FALL_STEP : target;
		end else begin
			level_nxt = level_q;
		end

		s1_go    = valid_s1 & (~upd | ~out_valid | out_ready);
		upd_go   = s1_go & upd;
		in_ready = ~valid_s1 | s1_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_upd_q  <= '0;
			last_beat_q <= '0;
			level_q     <= '0;
		end else if (upd_go) begin
			last_upd_q <= now_s1;
			level_q    <= level_nxt;
			if (restart) begin
				last_beat_q <= now_s1;
			end
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (upd_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			fade_level <= level_nxt;
		end
	end

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fade_level <= LEVEL_MAX)
		else $error("fade level above maximum");

	a_level_slew: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> (8'(level_q) <= 8'($past(level_q)) + 8'(RISE_STEP))
			&& (8'(level_q) + 8'(FALL_STEP) >= 8'($past(level_q))))
		else $error("fade level moved by more than one step");

	a_upd_time: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> last_upd_q == $past(now_s1))
		else $error("last update time not taken from the transfer");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> out_valid && fade_level == level_q)
		else $error("result does not match the new level");

endmodule

`default_nettype wire

/* hw/rtl/heartbeat_fade_envelope.sv */
// Heartbeat fade envelope top level: APB configuration and the fade update core.
// A time sample enters the input register; an updating one then loads the result register.
// Throughput: one sample per cycle; the input register, state and result register
// form one update step, so a stalled result only stalls an updating sample.
// Reset: asynchronous active low; speed and intensity return to 50, times and level to 0.
// Samples closer than 50 ms to the last update produce no result.
`default_nettype none

module heartbeat_fade_envelope (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [hbfe_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [hbfe_pkg::DATA_W-1:0]  pwdata,
	output logic      [hbfe_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [hbfe_pkg::TIME_W-1:0]  now_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [hbfe_pkg::LEVEL_W-1:0] fade_level
);
	import hbfe_pkg::*;

	hbfe_param_t param;

	hbfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.param   (param)
	);

	hbfe_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.param      (param),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fade_level (fade_level)
	);

endmodule

`default_nettype wire
